### sv/fsfa_pkg.sv
// fsfa_pkg: types and constants shared by the feature standardiser block
// payload structs, action and status codes, register indexes, fixed widths
// no dependencies
package fsfa_pkg;

  // action codes of an input beat
  localparam logic [1:0] ACT_FIT    = 2'd0;
  localparam logic [1:0] ACT_FINISH = 2'd1;
  localparam logic [1:0] ACT_LOAD   = 2'd2;
  localparam logic [1:0] ACT_APPLY  = 2'd3;

  // status codes of a result beat
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_NOFIT = 2'd2;

  // configuration register indexes
  localparam logic REG_FEATURE_COUNT = 1'b0;
  localparam logic REG_CLIP_LIMIT    = 1'b1;

  // field and storage widths
  localparam int VAL_W  = 24;
  localparam int SUM_W  = 40;
  localparam int SQS_W  = 64;
  localparam int ROW_W  = 17;
  localparam int FC_W   = 9;
  localparam int CNT_W  = 13;
  localparam int DVD_W  = 64;

  localparam logic [FC_W-1:0]  FC_RESET   = 9'd1;
  localparam logic [VAL_W-1:0] CLIP_RESET = 24'd196608;
  localparam logic [VAL_W-1:0] ONE_Q16    = 24'd65536;
  localparam logic [31:0]      UNITY_Q30  = 32'h4000_0000;
  localparam logic [VAL_W-1:0] STD_MAX    = 24'hFF_FFFF;

  typedef struct packed {
    logic [1:0]              action;
    logic [7:0]              feature_index;
    logic signed [VAL_W-1:0] sample;
    logic signed [VAL_W-1:0] mean_value;
    logic [VAL_W-1:0]        std_value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] normalised;
    logic [1:0]         status;
  } out_item_t;

  // request to the shared divider
  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [VAL_W-1:0] divisor;
  } div_req_t;

endpackage

### sv/fsfa_ram.sv
// fsfa_ram: generic single-write, single-read synchronous ram
// read data registered; no dependencies
module fsfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/fsfa_div.sv
// fsfa_div: restoring divider, one quotient bit per cycle, 64 steps
// depends on fsfa_pkg for widths and the request struct
module fsfa_div
  import fsfa_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  div_req_t         req,
  output logic             busy,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  logic [DVD_W-1:0] dvd_r;
  logic [VAL_W-1:0] dsr_r;
  logic [VAL_W-1:0] rem_r;
  logic [5:0]       step_r;
  logic             busy_r;
  logic             done_r;
  logic [VAL_W:0]   trial;
  logic             fits;

  // shift one dividend bit into the partial remainder
  assign trial = {rem_r, dvd_r[DVD_W-1]};
  assign fits  = trial >= {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= !req.start && busy_r && (step_r == 6'd63);
      if (req.start) begin
        dvd_r  <= req.dividend;
        dsr_r  <= req.divisor;
        rem_r  <= '0;
        step_r <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r  <= fits ? VAL_W'(trial - {1'b0, dsr_r}) : trial[VAL_W-1:0];
        dvd_r  <= {dvd_r[DVD_W-2:0], fits};
        step_r <= step_r + 6'd1;
        if (step_r == 6'd63) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = dvd_r;

endmodule

### sv/fsfa_isqrt.sv
// fsfa_isqrt: integer square root of a 64-bit value, two bits per cycle
// 32 steps; depends on fsfa_pkg for widths
module fsfa_isqrt
  import fsfa_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] value,
  output logic             done,
  output logic [31:0]      root
);

  logic [DVD_W-1:0] val_r;
  logic [33:0]      rem_r;
  logic [31:0]      root_r;
  logic [4:0]       step_r;
  logic             busy_r;
  logic             done_r;
  logic [35:0]      shifted;
  logic [35:0]      trial;
  logic             fits;

  // bring down the next bit pair and try root*4+1
  assign shifted = {rem_r, val_r[DVD_W-1:DVD_W-2]};
  assign trial   = {2'b00, root_r, 2'b01};
  assign fits    = shifted >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= !start && busy_r && (step_r == 5'd31);
      if (start) begin
        val_r  <= value;
        rem_r  <= '0;
        root_r <= '0;
        step_r <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r  <= fits ? 34'(shifted - trial) : shifted[33:0];
        root_r <= {root_r[30:0], fits};
        val_r  <= {val_r[DVD_W-3:0], 2'b00};
        step_r <= step_r + 5'd1;
        if (step_r == 5'd31) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

### sv/feature_standardizer_fit_apply_top.sv
// feature_standardizer_fit_apply_top: per-feature z-score standardiser
// depends on fsfa_pkg, fsfa_ram, fsfa_div and fsfa_isqrt
//
// Usage
//   in_*  : one beat per item (fit sample, finish, load entry, apply), valid/stall.
//   out_* : exactly one result beat per item, in order, valid/stall.
//   cfg_* : register writes (0 feature_count, 1 clip_limit), valid/ready,
//           cfg_ready is always high; write only while the block is idle.
// Processing (one item in flight at a time)
//   load or out-of-range item : straight to the output register
//   fit sample                : read, add, write back of the sums
//   apply                     : one or two passes of the
//                               64-step shared divider
//   finish                    : per in-use feature, two
//                               divider passes and a 32-step square root,
//                               plus a clearing step per unused feature
// The statistics and accumulators live in two rams; finish sweeps every
// entry. After reset a clearing pass over all MAX_FEATURES entries fills
// the rams with their reset values; in_stall stays high through it.
// A new item is taken while a finished result waits on out_stall; the
// following result then waits in its last state until the output frees.
module feature_standardizer_fit_apply_top
  import fsfa_pkg::*;
#(
  parameter int MAX_FEATURES = 256,
  parameter int MAX_ROWS     = 65536
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic             cfg_index,
  input  logic [VAL_W-1:0] cfg_wdata
);

  localparam int AW      = MAX_FEATURES > 1 ? $clog2(MAX_FEATURES) : 1;
  localparam int ST_W    = 2 * VAL_W;
  localparam int ACC_W   = SUM_W + SQS_W;
  localparam logic [AW-1:0]    LAST_ADDR = AW'(MAX_FEATURES - 1);
  localparam logic [CNT_W-1:0] MAXF      = CNT_W'(MAX_FEATURES);
  localparam logic [ROW_W-1:0] ROW_LIMIT = ROW_W'(MAX_ROWS);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_FIT, S_AP_LAT, S_AP_DIV1, S_AP_DIV2,
    S_FIN_RD, S_FIN_LAT, S_FIN_MEAN, S_FIN_MSQ, S_FIN_EX2, S_FIN_SQRT,
    S_FIN_CLR, S_DONE
  } state_t;

  state_t                  state_r;
  in_item_t                item_r;
  logic [AW-1:0]           addr_r;
  logic [47:0]             sq_r;
  logic [SQS_W-1:0]        sqs_r;
  logic                    neg_r;
  logic signed [VAL_W-1:0] m_r;
  logic [47:0]             msq_r;
  logic                    fin_ok_r;
  logic [31:0]             res_norm_r;
  logic [1:0]              res_status_r;
  logic                    out_valid_r;
  out_item_t               out_data_r;
  logic [ROW_W-1:0]        row_count_r;
  logic                    row_partial_r;
  logic [FC_W-1:0]         fc_r;
  logic [VAL_W-1:0]        clip_r;

  logic [CNT_W-1:0]  cnt;
  logic              in_idx_ok;
  logic              in_take;
  logic              out_free;
  logic              last_addr;
  logic [VAL_W-1:0]  clip_eff;

  logic              st_we;
  logic [AW-1:0]     st_waddr;
  logic [ST_W-1:0]   st_wdata;
  logic [ST_W-1:0]   st_rdata;
  logic              acc_we;
  logic [AW-1:0]     acc_waddr;
  logic [ACC_W-1:0]  acc_wdata;
  logic [ACC_W-1:0]  acc_rdata;
  logic [AW-1:0]     raddr;

  div_req_t          div_req;
  logic              div_busy;
  logic              div_done;
  logic [DVD_W-1:0]  div_q;
  logic              sq_start;
  logic [DVD_W-1:0]  sq_value;
  logic              sq_done;
  logic [31:0]       sq_root;

  logic signed [SUM_W-1:0] acc_sum;
  logic [SUM_W-1:0]        sum_mag;
  logic signed [VAL_W:0]   diff;
  logic [VAL_W:0]          diff_mag;
  logic [VAL_W-1:0]        std_rd;
  logic signed [VAL_W-1:0] mean_sat;
  logic [VAL_W-1:0]        std_fin;
  logic [VAL_W-1:0]        std_load;
  logic [DVD_W-1:0]        n_half;
  logic [VAL_W:0]          x_mag;
  logic [31:0]             q_neg;

  // effective feature count and range check of the incoming beat
  assign cnt       = ({4'b0, fc_r} < MAXF) ? {4'b0, fc_r} : MAXF;
  assign in_idx_ok = {5'b0, in_data.feature_index} < cnt;
  assign in_take   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign last_addr = addr_r == LAST_ADDR;
  assign clip_eff  = (clip_r == '0) ? VAL_W'(1) : clip_r;
  assign n_half    = DVD_W'(row_count_r >> 1);

  assign in_stall  = state_r != S_IDLE;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // datapath helpers
  assign acc_sum  = acc_rdata[ACC_W-1:SQS_W];
  assign sum_mag  = acc_sum[SUM_W-1] ? SUM_W'(-acc_sum) : acc_sum;
  assign std_rd   = (st_rdata[VAL_W-1:0] == '0) ? VAL_W'(1) : st_rdata[VAL_W-1:0];
  assign diff     = (VAL_W+1)'(item_r.sample) - (VAL_W+1)'($signed(st_rdata[ST_W-1:VAL_W]));
  assign diff_mag = diff[VAL_W] ? (VAL_W+1)'(-diff) : diff;
  assign x_mag    = in_data.sample[VAL_W-1] ? (VAL_W+1)'(-(VAL_W+1)'(in_data.sample))
                                            : (VAL_W+1)'(in_data.sample);
  assign std_load = (in_data.std_value == '0) ? VAL_W'(1) : in_data.std_value;
  assign q_neg    = 32'(-div_q[31:0]);

  // rounded mean, saturated to the signed 24-bit range
  always_comb begin
    if (neg_r) begin
      mean_sat = (div_q > DVD_W'(24'h80_0000)) ? $signed(24'h80_0000)
                                               : $signed(VAL_W'(-div_q[VAL_W-1:0]));
    end else begin
      mean_sat = (div_q > DVD_W'(24'h7F_FFFF)) ? $signed(24'h7F_FFFF)
                                               : $signed(div_q[VAL_W-1:0]);
    end
  end

  // std from the square root, saturated and floored at one lsb
  always_comb begin
    if (sq_root > 32'(STD_MAX)) begin
      std_fin = STD_MAX;
    end else if (sq_root == '0) begin
      std_fin = VAL_W'(1);
    end else begin
      std_fin = sq_root[VAL_W-1:0];
    end
  end

  // ram ports and unit requests
  always_comb begin
    raddr     = (state_r == S_IDLE) ? AW'(in_data.feature_index) : addr_r;
    st_we     = 1'b0;
    st_waddr  = addr_r;
    st_wdata  = {m_r, std_fin};
    acc_we    = 1'b0;
    acc_waddr = addr_r;
    acc_wdata = '0;
    div_req   = '0;
    sq_start  = 1'b0;
    sq_value  = (div_q > DVD_W'(msq_r)) ? DVD_W'(div_q - DVD_W'(msq_r)) : '0;
    unique case (state_r)
      S_CLEAR: begin
        st_we    = 1'b1;
        st_wdata = {VAL_W'(0), ONE_Q16};
        acc_we   = 1'b1;
      end
      S_IDLE: begin
        if (in_take && in_data.action == ACT_LOAD && in_idx_ok) begin
          st_we    = 1'b1;
          st_waddr = AW'(in_data.feature_index);
          st_wdata = {in_data.mean_value, std_load};
        end
      end
      S_FIT: begin
        acc_we    = 1'b1;
        acc_wdata = {SUM_W'(acc_sum + SUM_W'(item_r.sample)),
                     SQS_W'(acc_rdata[SQS_W-1:0] + SQS_W'(sq_r))};
      end
      S_AP_LAT: begin
        div_req.start    = 1'b1;
        div_req.dividend = DVD_W'({diff_mag, 16'b0});
        div_req.divisor  = std_rd;
      end
      S_AP_DIV1: begin
        if (div_done && div_q < DVD_W'(clip_eff)) begin
          div_req.start    = 1'b1;
          div_req.dividend = {div_q[33:0], 30'b0};
          div_req.divisor  = clip_eff;
        end
      end
      S_FIN_LAT: begin
        div_req.start    = 1'b1;
        div_req.dividend = DVD_W'(sum_mag) + n_half;
        div_req.divisor  = VAL_W'(row_count_r);
      end
      S_FIN_MSQ: begin
        div_req.start    = 1'b1;
        div_req.dividend = sqs_r;
        div_req.divisor  = VAL_W'(row_count_r);
      end
      S_FIN_EX2: begin
        sq_start = div_done;
      end
      S_FIN_SQRT: begin
        st_we  = sq_done;
        acc_we = sq_done;
      end
      S_FIN_CLR: begin
        acc_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // sequencer, row bookkeeping, configuration and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_CLEAR;
      addr_r        <= '0;
      out_valid_r   <= 1'b0;
      row_count_r   <= '0;
      row_partial_r <= 1'b0;
      fc_r          <= FC_RESET;
      clip_r        <= CLIP_RESET;
      fin_ok_r      <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_FEATURE_COUNT: fc_r   <= cfg_wdata[FC_W-1:0];
          REG_CLIP_LIMIT:    clip_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
      // output register drains; a waiting result reloads it in S_DONE
      if (out_valid_r && !out_stall && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLEAR: begin
          addr_r <= last_addr ? '0 : addr_r + AW'(1);
          if (last_addr) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_take) begin
            item_r       <= in_data;
            addr_r       <= (in_data.action == ACT_FINISH) ? '0
                                                           : AW'(in_data.feature_index);
            sq_r         <= 48'(x_mag * x_mag);
            res_norm_r   <= '0;
            res_status_r <= (in_data.action != ACT_FINISH && !in_idx_ok) ? ST_RANGE
                                                                         : ST_OK;
            if (in_data.action == ACT_FINISH) begin
              fin_ok_r <= (row_count_r != '0) && !row_partial_r;
              state_r  <= ((row_count_r != '0) && !row_partial_r) ? S_FIN_RD : S_FIN_CLR;
            end else if (!in_idx_ok) begin
              state_r      <= S_DONE;
            end else if (in_data.action == ACT_FIT) begin
              state_r <= (row_count_r < ROW_LIMIT) ? S_FIT : S_DONE;
            end else if (in_data.action == ACT_APPLY) begin
              state_r <= S_AP_LAT;
            end else begin
              state_r <= S_DONE;
            end
          end
        end
        S_FIT: begin
          if ({5'b0, item_r.feature_index} == cnt - CNT_W'(1)) begin
            row_count_r   <= row_count_r + ROW_W'(1);
            row_partial_r <= 1'b0;
          end else begin
            row_partial_r <= 1'b1;
          end
          state_r <= S_DONE;
        end
        S_AP_LAT: begin
          neg_r   <= diff[VAL_W];
          state_r <= S_AP_DIV1;
        end
        S_AP_DIV1: begin
          if (div_done) begin
            if (div_q >= DVD_W'(clip_eff)) begin
              res_norm_r <= neg_r ? 32'(-UNITY_Q30) : UNITY_Q30;
              state_r    <= S_DONE;
            end else begin
              state_r <= S_AP_DIV2;
            end
          end
        end
        S_AP_DIV2: begin
          if (div_done) begin
            res_norm_r <= neg_r ? q_neg : div_q[31:0];
            state_r    <= S_DONE;
          end
        end
        S_FIN_RD: begin
          state_r <= ({{(CNT_W-AW){1'b0}}, addr_r} < cnt) ? S_FIN_LAT : S_FIN_CLR;
        end
        S_FIN_LAT: begin
          sqs_r   <= acc_rdata[SQS_W-1:0];
          neg_r   <= acc_sum[SUM_W-1];
          state_r <= S_FIN_MEAN;
        end
        S_FIN_MEAN: begin
          if (div_done) begin
            m_r     <= mean_sat;
            state_r <= S_FIN_MSQ;
          end
        end
        S_FIN_MSQ: begin
          msq_r   <= 48'(m_r * m_r);
          state_r <= S_FIN_EX2;
        end
        S_FIN_EX2: begin
          if (div_done) begin
            state_r <= S_FIN_SQRT;
          end
        end
        S_FIN_SQRT, S_FIN_CLR: begin
          if (state_r == S_FIN_CLR || sq_done) begin
            addr_r <= addr_r + AW'(1);
            if (last_addr) begin
              row_count_r   <= '0;
              row_partial_r <= 1'b0;
              res_status_r  <= fin_ok_r ? ST_OK : ST_NOFIT;
              state_r       <= S_DONE;
            end else begin
              state_r <= fin_ok_r ? S_FIN_RD : S_FIN_CLR;
            end
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_r           <= 1'b1;
            out_data_r.normalised <= res_norm_r;
            out_data_r.status     <= res_status_r;
            state_r               <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  fsfa_ram #(.WIDTH(ST_W), .DEPTH(MAX_FEATURES)) u_stat_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (raddr),
    .rdata (st_rdata)
  );

  fsfa_ram #(.WIDTH(ACC_W), .DEPTH(MAX_FEATURES)) u_acc_ram (
    .clk   (clk),
    .we    (acc_we),
    .waddr (acc_waddr),
    .wdata (acc_wdata),
    .raddr (raddr),
    .rdata (acc_rdata)
  );

  fsfa_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  fsfa_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .value (sq_value),
    .done  (sq_done),
    .root  (sq_root)
  );

  // divider is never restarted mid-division
  a_div_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_busy)
    else $error("divider started while busy");

  // a pending result is held until the output register frees
  a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DONE && out_valid_r && out_stall |=> state_r == S_DONE)
    else $error("result left before output register freed");

  // only ok results carry a non-zero value
  a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.status != ST_OK |-> out_data_r.normalised == '0)
    else $error("non-ok result with non-zero value");

  // row counter never passes the limit
  a_row_limit: assert property (@(posedge clk) disable iff (!rst_n)
    row_count_r <= ROW_LIMIT)
    else $error("row count beyond limit");

endmodule

### verif/feature_standardizer_fit_apply_top_tb.sv
// testbench for feature_standardizer_fit_apply_top: directed table, then random sessions
// of fit rows, finishes, loads and applies, each result checked against a local predictor
// or typed value; depends on fsfa_pkg and the rtl of feature_standardizer_fit_apply_top
`timescale 1ns / 100ps

module feature_standardizer_fit_apply_top_tb;
  import fsfa_pkg::*;

  localparam int NFEAT = 256;
  localparam int NROWS = 65536;

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t want;
  } dir_row_t;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  in_item_t         in_data;
  logic             out_valid;
  logic             out_stall;
  out_item_t        out_data;
  logic             cfg_valid;
  logic             cfg_ready;
  logic             cfg_index;
  logic [VAL_W-1:0] cfg_wdata;

  // predictor state
  logic signed [VAL_W-1:0] mean_tab [NFEAT];
  logic [VAL_W-1:0]        std_tab  [NFEAT];
  logic [SUM_W-1:0]        sum_tab  [NFEAT];
  logic [SQS_W-1:0]        sqs_tab  [NFEAT];
  int unsigned             rows_done;
  bit                      row_open;
  logic [FC_W-1:0]         feat_cfg;
  logic [VAL_W-1:0]        clip_cfg;

  out_item_t  expected_results [$];
  dir_row_t   dir_tab [$];
  int         beats_taken = 0;
  int         errors = 0;
  int         hold_asked;
  int         hold_done;
  int         burst_left;

  feature_standardizer_fit_apply_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // 20 ns clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic logic [63:0] isqrt64(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b   = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v   = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic void clear_sums();
    for (int d = 0; d < NFEAT; d++) begin
      sum_tab[d] = '0;
      sqs_tab[d] = '0;
    end
    rows_done = 0;
    row_open  = 1'b0;
  endfunction

  // derive mean and std of every feature in use from the sums; nofit if no row or an open row
  function automatic logic [1:0] finish_stats(int cnt);
    longint      s;
    longint      m;
    logic [63:0] mag, q, n, msq, ex2, var_q, sd;
    n = rows_done;
    if (n == 0 || row_open) begin
      clear_sums();
      return ST_NOFIT;
    end
    for (int d = 0; d < cnt; d++) begin
      s   = {{(64-SUM_W){sum_tab[d][SUM_W-1]}}, sum_tab[d]};
      mag = (s < 0) ? -s : s;
      q   = (mag + n / 2) / n;
      if (s < 0) m = (q > 64'd8388608) ? -64'sd8388608 : -longint'(q);
      else       m = (q > 64'd8388607) ? 64'sd8388607 : longint'(q);
      msq   = m * m;
      ex2   = sqs_tab[d] / n;
      var_q = (ex2 > msq) ? ex2 - msq : 0;
      sd    = isqrt64(var_q);
      if (sd > STD_MAX) sd = STD_MAX;
      if (sd < 1) sd = 1;
      mean_tab[d] = m[VAL_W-1:0];
      std_tab[d]  = sd[VAL_W-1:0];
    end
    clear_sums();
    return ST_OK;
  endfunction

  function automatic logic [31:0] standardise(int idx, longint x);
    longint      diff;
    logic [63:0] mag, sd, cl, z, r;
    diff = x - longint'(mean_tab[idx]);
    mag  = (diff < 0) ? -diff : diff;
    sd   = (std_tab[idx] == 0) ? 1 : std_tab[idx];
    cl   = (clip_cfg == 0) ? 1 : clip_cfg;
    z    = (mag << 16) / sd;
    r    = (z >= cl) ? (64'd1 << 30) : (z << 30) / cl;
    if (diff < 0) r = -r;
    return r[31:0];
  endfunction

  // expected result of one accepted item, updating the predictor state
  function automatic out_item_t compute_result(in_item_t it);
    out_item_t   res;
    int          cnt;
    int          idx;
    longint      x;
    logic [63:0] mag;
    cnt = (feat_cfg > NFEAT) ? NFEAT : feat_cfg;
    idx = it.feature_index;
    x   = longint'(it.sample);
    res = '0;
    if (it.action == ACT_FINISH) begin
      res.status = finish_stats(cnt);
    end else if (idx >= cnt) begin
      res.status = ST_RANGE;
    end else if (it.action == ACT_FIT) begin
      if (rows_done < NROWS) begin
        mag = (x < 0) ? -x : x;
        sum_tab[idx] = sum_tab[idx] + {{(SUM_W-VAL_W){it.sample[VAL_W-1]}}, it.sample};
        sqs_tab[idx] = sqs_tab[idx] + mag * mag;
        if (idx == cnt - 1) begin
          rows_done++;
          row_open = 1'b0;
        end else begin
          row_open = 1'b1;
        end
      end
    end else if (it.action == ACT_LOAD) begin
      mean_tab[idx] = it.mean_value;
      std_tab[idx]  = (it.std_value < 1) ? VAL_W'(1) : it.std_value;
    end else begin
      res.normalised = standardise(idx, x);
    end
    return res;
  endfunction

  // accepted input beat: predict, or take the typed value of a directed row
  always @(posedge clk) begin
    out_item_t p;
    if (rst_n && in_valid && !in_stall) begin
      p = compute_result(in_data);
      if (beats_taken < dir_tab.size() && dir_tab[beats_taken].typed)
        p = dir_tab[beats_taken].want;
      expected_results.push_back(p);
      beats_taken++;
    end
  end

  // register writes seen by the predictor
  always @(posedge clk) begin
    if (rst_n && cfg_valid && cfg_ready) begin
      if (cfg_index == REG_FEATURE_COUNT) feat_cfg = cfg_wdata[FC_W-1:0];
      else                                clip_cfg = cfg_wdata;
    end
  end

  // accepted result beat against the oldest expectation
  always @(posedge clk) begin
    out_item_t w;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("result beat with nothing expected: normalised %0d status %0d",
               out_data.normalised, out_data.status);
        errors++;
      end else begin
        w = expected_results.pop_front();
        if (out_data.normalised !== w.normalised) begin
          $error("normalised: expected %0d actual %0d", w.normalised, out_data.normalised);
          errors++;
        end
        if (out_data.status !== w.status) begin
          $error("status: expected %0d actual %0d", w.status, out_data.status);
          errors++;
        end
      end
    end
  end

  // receiver stall pattern, with a long hold-off when a phase asks for one
  always @(posedge clk) begin
    int cyc;
    int mode;
    int hold_left;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (hold_asked != hold_done) begin
      hold_done++;
      hold_left = 600;
      out_stall <= 1'b1;
    end else begin
      cyc++;
      if (cyc % 50 == 0) mode = $urandom_range(3);
      case (mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(3) == 0);
        2: out_stall <= ($urandom_range(3) != 0);
        default: out_stall <= ((cyc % 5) < 2);
      endcase
    end
  end

  // one input beat, after a random gap between bursts
  task automatic send_item(in_item_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(12, 1);
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(6, 1);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [VAL_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic in_item_t mk(logic [1:0] act, int idx, int x, int mv = 0, int sv = 0);
    in_item_t it;
    it.action        = act;
    it.feature_index = 8'(idx);
    it.sample        = VAL_W'(x);
    it.mean_value    = VAL_W'(mv);
    it.std_value     = VAL_W'(sv);
    return it;
  endfunction

  function automatic void add_row(in_item_t it, bit typed = 0,
                                  logic [31:0] nv = 0, logic [1:0] st = ST_OK);
    dir_row_t r;
    r.item  = it;
    r.typed = typed;
    r.want.normalised = nv;
    r.want.status     = st;
    dir_tab.push_back(r);
  endfunction

  function automatic int rand_value();
    case ($urandom_range(4))
      0: return ($urandom_range(1) == 0) ? 8388607 : -8388608;
      1: return int'($urandom_range(131072)) - 65536;
      2: return int'($urandom_range(1024)) - 512;
      default: return {{8{1'b0}}, 24'($urandom)} - 8388608;
    endcase
  endfunction

  function automatic in_item_t random_item(int cnt);
    in_item_t it;
    it = in_item_t'({$urandom, $urandom, $urandom});
    it.sample = VAL_W'(rand_value());
    if (cnt > 0 && $urandom_range(3) != 0) it.feature_index = 8'($urandom_range(cnt - 1));
    return it;
  endfunction

  // fit rows then finish then applies, or noise and broken rows
  task automatic run_session(int cnt, inout int budget);
    int nrows;
    if (cnt > 0 && $urandom_range(9) < 7) begin
      nrows = (cnt > 16) ? 1 : $urandom_range(4, 1);
      for (int r = 0; r < nrows; r++)
        for (int d = 0; d < cnt; d++) begin
          send_item(mk(ACT_FIT, d, rand_value()));
          budget--;
        end
      if ($urandom_range(5) == 0) begin
        send_item(mk(ACT_FIT, $urandom_range(cnt - 1), rand_value()));
        budget--;
      end
      send_item(mk(ACT_FINISH, $urandom_range(255), rand_value()));
      repeat ($urandom_range(10, 3)) begin
        send_item(mk(ACT_APPLY, $urandom_range(cnt - 1), rand_value()));
        budget--;
      end
      budget--;
    end else begin
      repeat ($urandom_range(8, 2)) begin
        send_item(random_item(cnt));
        budget--;
      end
    end
  endtask

  task automatic run_phase(int fc, int clip, int budget, bit hold);
    int cnt;
    wait_idle();
    write_reg(REG_FEATURE_COUNT, VAL_W'(fc));
    write_reg(REG_CLIP_LIMIT, VAL_W'(clip));
    cnt = (fc > NFEAT) ? NFEAT : fc;
    if (hold) hold_asked++;
    while (budget > 0) run_session(cnt, budget);
  endtask

  // stimulus
  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    cfg_valid  = 1'b0;
    cfg_index  = REG_FEATURE_COUNT;
    cfg_wdata  = '0;
    hold_asked = 0;
    hold_done  = 0;
    burst_left = 0;
    for (int d = 0; d < NFEAT; d++) begin
      mean_tab[d] = '0;
      std_tab[d]  = ONE_Q16;
    end
    clear_sums();
    feat_cfg = FC_RESET;
    clip_cfg = CLIP_RESET;

    // directed rows, reset configuration
    add_row(mk(ACT_APPLY, 0, 0), 1, 0, ST_OK);
    add_row(mk(ACT_APPLY, 0, 65536), 1, 32'd357913941, ST_OK);
    add_row(mk(ACT_APPLY, 0, 8388607), 1, UNITY_Q30, ST_OK);
    add_row(mk(ACT_APPLY, 0, -8388608), 1, 32'hC000_0000, ST_OK);
    add_row(mk(ACT_APPLY, 255, 77), 1, 0, ST_RANGE);
    add_row(mk(ACT_FIT, 1, 5), 1, 0, ST_RANGE);
    add_row(mk(ACT_LOAD, 200, 0, 7, 9), 1, 0, ST_RANGE);
    add_row(mk(ACT_FINISH, 0, 0), 1, 0, ST_NOFIT);
    add_row(mk(ACT_LOAD, 0, 0, -8388608, 0), 1, 0, ST_OK);
    add_row(mk(ACT_APPLY, 0, 8388607));
    add_row(mk(ACT_APPLY, 0, -8388608), 1, 0, ST_OK);
    add_row(mk(ACT_LOAD, 0, 0, 8388607, 16777215), 1, 0, ST_OK);
    add_row(mk(ACT_APPLY, 0, 0));
    add_row(mk(ACT_APPLY, 0, -8388608));
    add_row(mk(ACT_FIT, 0, 65536), 1, 0, ST_OK);
    add_row(mk(ACT_FIT, 0, -65536), 1, 0, ST_OK);
    add_row(mk(ACT_FIT, 0, 8388607), 1, 0, ST_OK);
    add_row(mk(ACT_FIT, 0, -8388608), 1, 0, ST_OK);
    add_row(mk(ACT_FINISH, 0, 0), 1, 0, ST_OK);
    add_row(mk(ACT_APPLY, 0, 12345));
    add_row(mk(ACT_FINISH, 0, 0), 1, 0, ST_NOFIT);
    add_row(mk(ACT_FIT, 0, 100), 1, 0, ST_OK);
    add_row(mk(ACT_FINISH, 0, 0), 1, 0, ST_OK);
    add_row(mk(ACT_APPLY, 0, 100), 1, 0, ST_OK);
    add_row(mk(ACT_APPLY, 0, 300));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[i]) send_item(dir_tab[i].item);

    // random phases, extremes of both registers among them
    run_phase(4, 65536, 200, 1);
    run_phase(3, 1, 120, 0);
    run_phase(511, 16777215, 260, 0);
    run_phase(0, 196608, 15, 0);
    run_phase(2, $urandom_range(16777215, 1), 120, 0);
    run_phase(1, 16777215, 80, 0);
    run_phase($urandom_range(12, 5), $urandom_range(400000, 1000), 120, 0);

    wait_idle();
    repeat (200) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      if (expected_results.size() != 0)
        $error("%0d expected results never arrived", expected_results.size());
      $display("Simulation FAILED");
    end
    $finish;
  end

  // overall time limit
  initial begin
    #60ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

### filelist.f
sv/fsfa_pkg.sv
sv/fsfa_ram.sv
sv/fsfa_div.sv
sv/fsfa_isqrt.sv
sv/feature_standardizer_fit_apply_top.sv
verif/feature_standardizer_fit_apply_top_tb.sv
